>>> hdl/rarmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rarmt_pkg;

  // Field widths fixed by the stream format
  localparam int DATA_W      = 64;
  localparam int POS_W       = 11;
  localparam int CMD_W       = 2;
  localparam int IN_TDATA_W  = 88;  // start, end, operand, zero fill to bytes
  localparam int OUT_TDATA_W = 80;  // min_value, position, zero fill to bytes
  localparam int OUT_TUSER_W = 2;   // empty_range, no_match

  // Command codes carried on in_tuser
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MIN    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [DATA_W-1:0] MAX_S64 = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef logic [DATA_W-1:0] word_t;

endpackage

`default_nettype wire

>>> hdl/range_add_range_min_tree.sv
`timescale 1ns / 1ps
`default_nettype none

// Lazy segment tree over LEAVES signed 64-bit elements with range add, range
// minimum and leftmost at-most-threshold search. After reset the block runs a
// clearing pass over every node of its memories and shows in_tready low
// meanwhile. It then takes one command at a time: in_tready is high only
// while no command is in work. Commands walk the tree one level at a time
// through a small set of 64-bit adders and signed compares under one sequencer,
// next to two node memories with two registered read ports each.
// A range minimum walks down each range boundary in turn, a search walks down
// to the start leaf and then descends from the matching node, and a range add
// applies the pending adds bottom up and then refreshes the minima of both
// boundary paths. The result sits in an output register, so the next command is
// taken while it waits for out_tready; a fresh result waits if the old one has
// not been taken yet. Sums wrap in 64-bit two's complement.
module range_add_range_min_tree #(
  parameter int LEAVES = 1024
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // [10:0] range_start, [21:11] range_end, [85:22] operand, [87:86] zero
  input  wire [rarmt_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] cmd
  input  wire [rarmt_pkg::CMD_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // [63:0] min_value, [74:64] position, [79:75] zero
  output logic [rarmt_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] empty_range, [1] no_match
  output logic [rarmt_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import rarmt_pkg::*;

  localparam int LOG  = $clog2(LEAVES);
  localparam int IW   = LOG + 1;              // leaf index, up to LEAVES
  localparam int AW   = LOG + 1;              // node address, 0 .. 2*LEAVES-1
  localparam int NW   = LOG + 2;              // add sweep bounds, up to 2*LEAVES
  localparam int CW   = (POS_W > IW) ? POS_W : IW;
  localparam int NODES = 2 * LEAVES;
  localparam logic [AW-1:0] LAST_NODE = AW'(NODES - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ADD_CHK, S_ADD_WR, S_UPD_RD, S_UPD_OWN, S_UPD_WR,
    S_ROOT_RD, S_ROOT_CHK, S_WALK_RD, S_WALK_OWN, S_WALK_EVAL,
    S_DESC_CHK, S_DESC_EVAL, S_FIN
  } state_t;

  state_t state_r;

  // Node memories: node minimum and pending add per node
  word_t nm_mem [NODES];
  word_t pd_mem [NODES];
  word_t nm_rd0_r, nm_rd1_r, pd_rd0_r, pd_rd1_r;

  logic [AW-1:0] ra0, ra1, wa;
  logic          nm_we, pd_we;
  word_t         nm_wd, pd_wd;

  // Command registers
  logic [CMD_W-1:0] cmd_r;
  logic [IW-1:0]    a_r, b_r;
  word_t            w_r;

  // Add sweep and minimum refresh
  logic [NW-1:0] l_r, r_r, rm1;
  logic          ph_r;
  logic [AW-1:0] wa_r;
  logic [AW-1:0] p1_r, p2_r, upd_p;
  logic          upsel_r;

  // Tree walk
  logic [AW-1:0] k_r;
  logic [IW-1:0] lo_r, sz_r, tgt_r;
  word_t         acc_r, kp_r, accp_r, own0_r, own1_r, pdc0_r, pdc1_r;
  logic          wsel_r, desc_r;
  word_t         best_r;
  logic          have_r;
  logic          win_r;
  logic [AW-1:0] win_k_r;
  word_t         win_acc_r, win_pend_r;
  logic [AW-1:0] clr_r;

  // Result and output registers
  word_t         res_min_r;
  logic [IW-1:0] res_pos_r;
  logic          res_empty_r, res_nom_r;
  logic          out_valid_r;
  word_t         out_min_r;
  logic [IW-1:0] out_pos_r;
  logic          out_empty_r, out_nom_r;

  // Input fields and clamped bounds
  logic [POS_W-1:0] in_start, in_end;
  word_t            in_operand;
  logic [CW-1:0]    a_ext, b_ext;
  logic [IW-1:0]    a_in, b_in;

  assign in_start   = in_tdata[POS_W-1:0];
  assign in_end     = in_tdata[2*POS_W-1:POS_W];
  assign in_operand = in_tdata[2*POS_W+DATA_W-1:2*POS_W];

  always_comb begin
    a_ext = CW'(in_start);
    b_ext = CW'(in_end);
    a_in  = (a_ext > CW'(LEAVES)) ? IW'(LEAVES) : IW'(a_ext);
    b_in  = (b_ext > CW'(LEAVES)) ? IW'(LEAVES) : IW'(b_ext);
  end

  // Walk step: split the current node, score both children
  word_t         s0, s1, s_c, s_o, root_own;
  logic [IW-1:0] half, mid, lo_c, lo_o;
  logic          go, full_c, full_o, le_c, le_o, le0, root_le;
  logic [AW-1:0] kc, ko;
  word_t         ev_best, ev_win_acc, ev_win_pend;
  logic          ev_have, ev_win;
  logic [AW-1:0] ev_win_k;
  word_t         upd_min;

  always_comb begin
    s0       = accp_r + own0_r;
    s1       = accp_r + own1_r;
    half     = sz_r >> 1;
    mid      = lo_r + half;
    go       = (tgt_r >= mid);
    lo_c     = go ? mid : lo_r;
    lo_o     = go ? lo_r : mid;
    s_c      = go ? s1 : s0;
    s_o      = go ? s0 : s1;
    full_c   = (lo_c >= a_r) && (IW'(lo_c + half) <= b_r);
    full_o   = (lo_o >= a_r) && (IW'(lo_o + half) <= b_r);
    le_c     = ($signed(s_c) <= $signed(w_r));
    le_o     = ($signed(s_o) <= $signed(w_r));
    le0      = ($signed(s0) <= $signed(w_r));
    kc       = {k_r[AW-2:0], go};
    ko       = {k_r[AW-2:0], ~go};
    root_own = nm_rd0_r + pd_rd0_r;
    root_le  = ($signed(root_own) <= $signed(w_r));

    // running minimum over nodes that lie wholly inside the range
    ev_best = best_r;
    ev_have = have_r;
    if (full_o && (!ev_have || ($signed(s_o) < $signed(ev_best)))) begin
      ev_best = s_o;
      ev_have = 1'b1;
    end
    if (full_c && (!ev_have || ($signed(s_c) < $signed(ev_best)))) begin
      ev_best = s_c;
      ev_have = 1'b1;
    end

    // deeper match wins; the path child itself outranks its sibling
    ev_win      = win_r;
    ev_win_k    = win_k_r;
    ev_win_acc  = win_acc_r;
    ev_win_pend = win_pend_r;
    if (full_o && le_o) begin
      ev_win      = 1'b1;
      ev_win_k    = ko;
      ev_win_acc  = accp_r;
      ev_win_pend = go ? pdc0_r : pdc1_r;
    end
    if (full_c && le_c) begin
      ev_win      = 1'b1;
      ev_win_k    = kc;
      ev_win_acc  = accp_r;
      ev_win_pend = go ? pdc1_r : pdc0_r;
    end

    upd_min = ($signed(own0_r) <= $signed(own1_r)) ? own0_r : own1_r;
    rm1     = r_r - NW'(1);
    upd_p   = upsel_r ? p2_r : p1_r;
  end

  // Memory port control
  always_comb begin
    ra0   = '0;
    ra1   = '0;
    wa    = '0;
    nm_we = 1'b0;
    pd_we = 1'b0;
    nm_wd = '0;
    pd_wd = '0;
    unique case (state_r)
      S_CLR: begin
        nm_we = 1'b1;
        pd_we = 1'b1;
        wa    = clr_r;
      end
      S_ADD_CHK: ra0 = ph_r ? rm1[AW-1:0] : l_r[AW-1:0];
      S_ADD_WR: begin
        pd_we = 1'b1;
        wa    = wa_r;
        pd_wd = pd_rd0_r + w_r;
      end
      S_UPD_RD: begin
        ra0 = {upd_p[AW-1:1], 1'b0};
        ra1 = {upd_p[AW-1:1], 1'b1};
      end
      S_UPD_WR: begin
        nm_we = 1'b1;
        wa    = {1'b0, upd_p[AW-1:1]};
        nm_wd = upd_min;
      end
      S_ROOT_RD: ra0 = AW'(1);
      S_WALK_RD: begin
        ra0 = {k_r[AW-2:0], 1'b0};
        ra1 = {k_r[AW-2:0], 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (nm_we) nm_mem[wa] <= nm_wd;
    if (pd_we) pd_mem[wa] <= pd_wd;
    nm_rd0_r <= nm_mem[ra0];
    nm_rd1_r <= nm_mem[ra1];
    pd_rd0_r <= pd_mem[ra0];
    pd_rd1_r <= pd_mem[ra1];
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - DATA_W - POS_W)'(0), POS_W'(out_pos_r), out_min_r};
  assign out_tuser  = {out_nom_r, out_empty_r};

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once the consumer takes the transfer, unless a new one loads
      if (out_valid_r && out_tready && state_r != S_FIN) out_valid_r <= 1'b0;

      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == LAST_NODE) state_r <= S_IDLE;
        end

        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= in_tuser;
            a_r     <= a_in;
            b_r     <= (in_tuser == CMD_SEARCH) ? IW'(LEAVES) : b_in;
            w_r     <= in_operand;
            tgt_r   <= a_in;
            wsel_r  <= 1'b0;
            desc_r  <= 1'b0;
            have_r  <= 1'b0;
            win_r   <= 1'b0;
            l_r     <= NW'(a_in) + NW'(LEAVES);
            r_r     <= NW'(b_in) + NW'(LEAVES);
            ph_r    <= 1'b0;
            case (in_tuser)
              CMD_ADD: if (a_in < b_in) state_r <= S_ADD_CHK;
              CMD_MIN: begin
                if (a_in < b_in) begin
                  state_r <= S_ROOT_RD;
                end else begin
                  res_min_r   <= MAX_S64;
                  res_empty_r <= 1'b1;
                  res_pos_r   <= '0;
                  res_nom_r   <= 1'b0;
                  state_r     <= S_FIN;
                end
              end
              CMD_SEARCH: begin
                if (a_in < IW'(LEAVES)) begin
                  state_r <= S_ROOT_RD;
                end else begin
                  res_min_r   <= '0;
                  res_empty_r <= 1'b0;
                  res_pos_r   <= IW'(LEAVES);
                  res_nom_r   <= 1'b1;
                  state_r     <= S_FIN;
                end
              end
              default: begin
              end
            endcase
          end
        end

        // Pending adds on the canonical nodes, bottom up
        S_ADD_CHK: begin
          if (!(l_r < r_r)) begin
            p1_r    <= AW'(a_r) + AW'(LEAVES);
            p2_r    <= AW'(b_r - IW'(1)) + AW'(LEAVES);
            upsel_r <= 1'b0;
            state_r <= S_UPD_RD;
          end else if (!ph_r) begin
            if (l_r[0]) begin
              wa_r    <= l_r[AW-1:0];
              state_r <= S_ADD_WR;
            end else begin
              ph_r <= 1'b1;
            end
          end else if (r_r[0]) begin
            r_r     <= rm1;
            wa_r    <= rm1[AW-1:0];
            state_r <= S_ADD_WR;
          end else begin
            l_r  <= l_r >> 1;
            r_r  <= r_r >> 1;
            ph_r <= 1'b0;
          end
        end

        S_ADD_WR: begin
          if (!ph_r) begin
            l_r  <= l_r + NW'(1);
            ph_r <= 1'b1;
          end else begin
            l_r  <= l_r >> 1;
            r_r  <= r_r >> 1;
            ph_r <= 1'b0;
          end
          state_r <= S_ADD_CHK;
        end

        // Refresh minima along both boundary paths, one level at a time
        S_UPD_RD: state_r <= (p1_r == AW'(1)) ? S_IDLE : S_UPD_OWN;

        S_UPD_OWN: begin
          own0_r  <= nm_rd0_r + pd_rd0_r;
          own1_r  <= nm_rd1_r + pd_rd1_r;
          state_r <= S_UPD_WR;
        end

        S_UPD_WR: begin
          if (!upsel_r) begin
            upsel_r <= 1'b1;
          end else begin
            p1_r    <= p1_r >> 1;
            p2_r    <= p2_r >> 1;
            upsel_r <= 1'b0;
          end
          state_r <= S_UPD_RD;
        end

        S_ROOT_RD: state_r <= S_ROOT_CHK;

        S_ROOT_CHK: begin
          k_r   <= AW'(1);
          lo_r  <= '0;
          sz_r  <= IW'(LEAVES);
          acc_r <= '0;
          kp_r  <= pd_rd0_r;
          if (cmd_r == CMD_MIN && a_r == '0 && b_r == IW'(LEAVES)) begin
            res_min_r   <= root_own;
            res_empty_r <= 1'b0;
            res_pos_r   <= '0;
            res_nom_r   <= 1'b0;
            state_r     <= S_FIN;
          end else if (cmd_r != CMD_MIN && a_r == '0) begin
            // whole array qualifies as the first candidate
            if (root_le) begin
              desc_r  <= 1'b1;
              state_r <= S_DESC_CHK;
            end else begin
              res_min_r   <= '0;
              res_empty_r <= 1'b0;
              res_pos_r   <= IW'(LEAVES);
              res_nom_r   <= 1'b1;
              state_r     <= S_FIN;
            end
          end else begin
            state_r <= S_WALK_RD;
          end
        end

        S_WALK_RD: state_r <= S_WALK_OWN;

        S_WALK_OWN: begin
          own0_r  <= nm_rd0_r + pd_rd0_r;
          own1_r  <= nm_rd1_r + pd_rd1_r;
          pdc0_r  <= pd_rd0_r;
          pdc1_r  <= pd_rd1_r;
          accp_r  <= acc_r + kp_r;
          state_r <= desc_r ? S_DESC_EVAL : S_WALK_EVAL;
        end

        S_WALK_EVAL: begin
          best_r     <= ev_best;
          have_r     <= ev_have;
          win_r      <= ev_win;
          win_k_r    <= ev_win_k;
          win_acc_r  <= ev_win_acc;
          win_pend_r <= ev_win_pend;
          if (full_c) begin
            if (cmd_r == CMD_MIN) begin
              if (!wsel_r) begin
                // second walk down the right boundary
                wsel_r  <= 1'b1;
                tgt_r   <= b_r - IW'(1);
                state_r <= S_ROOT_RD;
              end else begin
                res_min_r   <= ev_best;
                res_empty_r <= 1'b0;
                res_pos_r   <= '0;
                res_nom_r   <= 1'b0;
                state_r     <= S_FIN;
              end
            end else if (ev_win) begin
              k_r     <= ev_win_k;
              acc_r   <= ev_win_acc;
              kp_r    <= ev_win_pend;
              desc_r  <= 1'b1;
              state_r <= S_DESC_CHK;
            end else begin
              res_min_r   <= '0;
              res_empty_r <= 1'b0;
              res_pos_r   <= IW'(LEAVES);
              res_nom_r   <= 1'b1;
              state_r     <= S_FIN;
            end
          end else begin
            k_r     <= kc;
            lo_r    <= lo_c;
            sz_r    <= half;
            acc_r   <= accp_r;
            kp_r    <= go ? pdc1_r : pdc0_r;
            state_r <= S_WALK_RD;
          end
        end

        // Descend from the matching node toward its leftmost qualifying leaf
        S_DESC_CHK: begin
          if (k_r[AW-1]) begin
            res_min_r   <= '0;
            res_empty_r <= 1'b0;
            res_pos_r   <= IW'(k_r[LOG-1:0]);
            res_nom_r   <= 1'b0;
            state_r     <= S_FIN;
          end else begin
            state_r <= S_WALK_RD;
          end
        end

        S_DESC_EVAL: begin
          k_r     <= {k_r[AW-2:0], ~le0};
          acc_r   <= accp_r;
          kp_r    <= le0 ? pdc0_r : pdc1_r;
          state_r <= S_DESC_CHK;
        end

        S_FIN: begin
          // hold until the output register is free
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_min_r   <= res_min_r;
            out_pos_r   <= res_pos_r;
            out_empty_r <= res_empty_r;
            out_nom_r   <= res_nom_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A query transfer in starts work, so the port closes on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_MIN || in_tuser == CMD_SEARCH)
    |=> !in_tready)
    else $error("input port stayed open after a transfer");

  // A new result only comes out of the finish step
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finish step");

  // Node 0 is unused; only the clearing pass may write it
  a_no_write_node0: assert property (@(posedge clk) disable iff (!rst_n)
    (nm_we || pd_we) && state_r != S_CLR |-> wa != '0)
    else $error("write to unused node 0");

  // Nothing is taken in while the memories are being cleared
  a_closed_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_tready && !out_tvalid)
    else $error("port active during clearing pass");

endmodule

`default_nettype wire

>>> dv/tb_range_add_range_min_tree.sv
`timescale 1ns / 1ps

module tb_range_add_range_min_tree;
  import rarmt_pkg::*;

  localparam int LEAVES = 1024;
  localparam int NODES  = 2 * LEAVES;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One command as it travels on the input stream
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  range_start;
    logic [POS_W-1:0]  range_end;
    logic [DATA_W-1:0] operand;
  } tree_cmd_t;

  // One answer as it leaves on the output stream
  typedef struct packed {
    logic [DATA_W-1:0] min_value;
    logic              empty_range;
    logic [POS_W-1:0]  position;
    logic              no_match;
  } tree_ans_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [CMD_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  // Shadow copy of the tree and the answers still owed by the block
  word_t shadow_min [NODES];
  word_t shadow_lazy [NODES];
  tree_ans_t owed_answers [$];

  int     err_count = 0;
  longint cycle_count = 0;
  bit     stall_enable = 1'b1;
  int     hold_cnt = 0;

  always #10 clk = ~clk;

  range_add_range_min_tree #(.LEAVES(LEAVES)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // Signed compare and min on raw 64-bit words
  function automatic bit s_le(word_t a, word_t b);
    return $signed(a) <= $signed(b);
  endfunction

  function automatic word_t s_min(word_t a, word_t b);
    return s_le(a, b) ? a : b;
  endfunction

  function automatic word_t full_val(int k);
    return shadow_min[k] + shadow_lazy[k];
  endfunction

  // Push an add into every canonical node of [a,b), then refresh minima upward
  function automatic void shadow_add(int k, int lo, int hi, int a, int b, word_t w);
    int mid;
    if (b <= lo || hi <= a) return;
    if (a <= lo && hi <= b) begin
      shadow_lazy[k] += w;
      return;
    end
    mid = lo + (hi - lo) / 2;
    shadow_add(2 * k, lo, mid, a, b, w);
    shadow_add(2 * k + 1, mid, hi, a, b, w);
    shadow_min[k] = s_min(full_val(2 * k), full_val(2 * k + 1));
  endfunction

  // Min over [a,b); acc carries the ancestors' pending adds
  function automatic bit shadow_range_min(int k, int lo, int hi, int a, int b,
                                          word_t acc, output word_t res);
    int mid;
    word_t l, r;
    bit hl, hr;
    res = '0;
    if (b <= lo || hi <= a) return 1'b0;
    if (a <= lo && hi <= b) begin
      res = acc + full_val(k);
      return 1'b1;
    end
    mid = lo + (hi - lo) / 2;
    acc += shadow_lazy[k];
    hl = shadow_range_min(2 * k, lo, mid, a, b, acc, l);
    hr = shadow_range_min(2 * k + 1, mid, hi, a, b, acc, r);
    if (hl && hr) res = s_min(l, r);
    else if (hl) res = l;
    else if (hr) res = r;
    return hl || hr;
  endfunction

  // Leftmost leaf at or after p whose value is at most x
  function automatic bit shadow_search(int k, int lo, int hi, int p, word_t acc,
                                       word_t x, output int pos);
    int mid;
    pos = 0;
    if (hi <= p) return 1'b0;
    if (lo >= p) begin
      if (!s_le(acc + full_val(k), x)) return 1'b0;
      while (k < LEAVES) begin
        acc += shadow_lazy[k];
        k = 2 * k;
        if (!s_le(acc + full_val(k), x)) k++;
      end
      pos = k - LEAVES;
      return 1'b1;
    end
    mid = lo + (hi - lo) / 2;
    acc += shadow_lazy[k];
    if (shadow_search(2 * k, lo, mid, p, acc, x, pos)) return 1'b1;
    return shadow_search(2 * k + 1, mid, hi, p, acc, x, pos);
  endfunction

  // Apply one accepted command to the shadow tree and queue its answer
  function automatic void predict_command(tree_cmd_t c);
    int a, b, pos;
    word_t res;
    tree_ans_t ans;
    a = (c.range_start > LEAVES) ? LEAVES : int'(c.range_start);
    b = (c.range_end > LEAVES) ? LEAVES : int'(c.range_end);
    ans = '0;
    case (c.cmd)
      CMD_ADD: begin
        if (a < b) shadow_add(1, 0, LEAVES, a, b, c.operand);
      end
      CMD_MIN: begin
        if (a < b && shadow_range_min(1, 0, LEAVES, a, b, '0, res)) begin
          ans.min_value = res;
        end else begin
          ans.min_value = MAX_S64;
          ans.empty_range = 1'b1;
        end
        owed_answers.push_back(ans);
      end
      CMD_SEARCH: begin
        if (a < LEAVES && shadow_search(1, 0, LEAVES, a, '0, c.operand, pos)) begin
          ans.position = pos[POS_W-1:0];
        end else begin
          ans.position = LEAVES[POS_W-1:0];
          ans.no_match = 1'b1;
        end
        owed_answers.push_back(ans);
      end
      default: ;  // unused code: no effect, no answer
    endcase
  endfunction

  // Send one command; hold tvalid until the transfer completes
  task automatic send_command(tree_cmd_t c);
    int gap;
    if (stall_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.cmd;
    in_tdata  <= {2'b00, c.operand, c.range_end, c.range_start};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_command(c);
  endtask

  function automatic tree_cmd_t make_cmd(logic [CMD_W-1:0] op, int s, int e, word_t w);
    tree_cmd_t c;
    c.cmd = op;
    c.range_start = s[POS_W-1:0];
    c.range_end = e[POS_W-1:0];
    c.operand = w;
    return c;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return 64'h8000_0000_0000_0000;
      2: return MAX_S64;
      default: return word_t'(signed'(64'($urandom_range(0, 200)) - 64'sd100));
    endcase
  endfunction

  // Mostly in-range spans, sometimes anywhere in the 11-bit field
  function automatic tree_cmd_t rand_cmd();
    int s, e;
    logic [CMD_W-1:0] op;
    op = ($urandom_range(0, 40) == 0) ? CMD_UNUSED : CMD_W'($urandom_range(0, 2));
    if ($urandom_range(0, 9) == 0) begin
      s = $urandom_range(0, 2047);
      e = $urandom_range(0, 2047);
    end else begin
      s = $urandom_range(0, LEAVES - 1);
      e = s + $urandom_range(0, ($urandom_range(0, 1) != 0) ? 16 : LEAVES - s);
    end
    return make_cmd(op, s, e, rand_word());
  endfunction

  // Close the input, wait until every owed answer is drained, plus settle time
  task automatic drain_answers();
    in_tvalid <= 1'b0;
    while (owed_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic test_edges();
    send_command(make_cmd(CMD_MIN, 0, LEAVES, '0));
    send_command(make_cmd(CMD_SEARCH, 0, 0, '0));
    send_command(make_cmd(CMD_SEARCH, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
    send_command(make_cmd(CMD_ADD, 0, LEAVES, MAX_S64));
    send_command(make_cmd(CMD_ADD, 3, 4, 64'd1));  // wraps past the top
    send_command(make_cmd(CMD_MIN, 0, LEAVES, '0));
    send_command(make_cmd(CMD_ADD, 5, 900, 64'h8000_0000_0000_0000));
    send_command(make_cmd(CMD_SEARCH, 4, 0, 64'h8000_0000_0000_0000));
    send_command(make_cmd(CMD_MIN, 700, 2047, '0));    // end past the array
    send_command(make_cmd(CMD_MIN, 2047, 2047, '0));   // start past the array
    send_command(make_cmd(CMD_MIN, 10, 10, '0));       // empty span
    send_command(make_cmd(CMD_MIN, 20, 10, '0));
    send_command(make_cmd(CMD_ADD, 30, 10, 64'd55));   // empty add
    send_command(make_cmd(CMD_SEARCH, LEAVES, 0, MAX_S64));
    send_command(make_cmd(CMD_SEARCH, 2047, 2047, MAX_S64));
    send_command(make_cmd(CMD_SEARCH, LEAVES - 1, 0, MAX_S64));
    send_command(make_cmd(CMD_UNUSED, 0, LEAVES, 64'd7));
    send_command(make_cmd(CMD_MIN, LEAVES - 1, LEAVES, '0));
    send_command(make_cmd(CMD_ADD, 0, LEAVES, 64'h5555_5555_5555_5555));
    send_command(make_cmd(CMD_SEARCH, 1, 0, 64'h2AAA_AAAA_AAAA_AAAA));
    drain_answers();
  endtask

  task automatic test_random_mix();
    repeat (900) send_command(rand_cmd());
    drain_answers();
  endtask

  task automatic test_back_to_back();
    stall_enable = 1'b0;
    repeat (200) send_command(rand_cmd());
    drain_answers();
  endtask

  // Receiver side: random stall bursts, compare each transfer with the oldest owed answer
  always @(posedge clk) begin
    tree_ans_t got, want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got.min_value   = out_tdata[63:0];
      got.position    = out_tdata[74:64];
      got.empty_range = out_tuser[0];
      got.no_match    = out_tuser[1];
      if (owed_answers.size() == 0) begin
        $display("%0t: unexpected answer %p", $time, got);
        err_count++;
      end else begin
        want = owed_answers.pop_front();
        if (got !== want) begin
          $display("%0t: expected %p actual %p", $time, want, got);
          err_count++;
        end
      end
    end
    if (!stall_enable) begin
      hold_cnt   <= 0;
      out_tready <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 40) == 0) begin
      hold_cnt   <= $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 4) != 0);
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("range_add_range_min_tree: mismatch");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < NODES; k++) begin
      shadow_min[k] = '0;
      shadow_lazy[k] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_edges();
    test_random_mix();
    test_back_to_back();
    if (err_count == 0) begin
      $display("range_add_range_min_tree: match");
    end else begin
      $display("range_add_range_min_tree: mismatch");
    end
    $finish;
  end

endmodule

>>> range_add_range_min_tree.f
hdl/rarmt_pkg.sv
hdl/range_add_range_min_tree.sv
dv/tb_range_add_range_min_tree.sv
